// ----- hw/rtl/fbpa_pkg.sv -----
// Shared types and codes for the fixed block pool allocator.
package fbpa_pkg;

    // Request codes carried in the action field.
    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    // Result status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_EMPTY   = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;
    localparam logic [1:0] ST_DOUBLE  = 2'd3;

    // Field widths fixed by the interface.
    localparam int INDEX_W = 16;
    localparam int COUNT_W = 9;
    localparam int TOTAL_W = 32;

    // One request transfer.
    typedef struct packed {
        logic               action;
        logic [INDEX_W-1:0] block_index;
    } req_t;

    // One result transfer.
    typedef struct packed {
        logic [1:0]         status;
        logic [INDEX_W-1:0] granted_index;
        logic [COUNT_W-1:0] free_blocks;
        logic [COUNT_W-1:0] used_blocks;
        logic [TOTAL_W-1:0] alloc_total;
        logic [TOTAL_W-1:0] free_total;
    } rsp_t;

endpackage

// ----- hw/rtl/fbpa_store.sv -----
// Link table and in-use mark memories, each with one write and one registered read port.
module fbpa_store #(
    parameter int DEPTH  = 256,
    parameter int IDX_W  = 8,
    parameter int LINK_W = 9
) (
    input  logic              clk,
    input  logic              rd_en,
    input  logic [IDX_W-1:0]  link_rd_addr,
    input  logic [IDX_W-1:0]  mark_rd_addr,
    output logic [LINK_W-1:0] link_rd_data,
    output logic              mark_rd_data,
    input  logic              link_we,
    input  logic [IDX_W-1:0]  link_wr_addr,
    input  logic [LINK_W-1:0] link_wr_data,
    input  logic              mark_we,
    input  logic [IDX_W-1:0]  mark_wr_addr,
    input  logic              mark_wr_data
);

    logic [LINK_W-1:0] link_mem [DEPTH];
    logic              mark_mem [DEPTH];

    // Link table: next free block for every block that has been freed at least once.
    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[link_wr_addr] <= link_wr_data;
        end
        if (rd_en)
        begin
            link_rd_data <= link_mem[link_rd_addr];
        end
    end

    // In-use marks for every block that has been handed out at least once.
    always_ff @(posedge clk)
    begin
        if (mark_we)
        begin
            mark_mem[mark_wr_addr] <= mark_wr_data;
        end
        if (rd_en)
        begin
            mark_rd_data <= mark_mem[mark_rd_addr];
        end
    end

endmodule

// ----- hw/rtl/fixed_block_pool_allocator.sv -----
// Top level of the fixed block pool allocator: request decode, list head and counters.
//
// Usage: a request transfer happens at a rising edge where start is high and busy
// is low. An allocate (action 0) pops the head of the free list; a free (action 1)
// returns the named block after checking its index and its in-use mark.
// Each request gives exactly one result, registered after the request has executed while
// busy is high: done is high for one cycle with the result fields valid. The receiver
// cannot stall, so the result is simply presented for that one cycle.
// Busy is raised by each transfer and stays high while the memories are
// read and written back, so no new request is taken while the last one executes.
// The pause comes from the registered read port of the link and mark memories. A
// new request may be taken in the same cycle that done shows the previous result.
// The free list lives in the link memory; blocks that were never handed out are
// tracked by a high-water mark, so no clearing pass is needed after reset.
// Reset: the list holds blocks 0, 1, 2, ... in order, all blocks are free and the
// totals are zero; the block accepts requests in the first cycle after reset.
module fixed_block_pool_allocator #(
    parameter int NUM_BLOCKS = 256
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  fbpa_pkg::req_t request,
    output logic          busy,
    output logic          done,
    output fbpa_pkg::rsp_t result
);

    import fbpa_pkg::*;

    localparam int IDX_W  = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int LINK_W = $clog2(NUM_BLOCKS + 1);
    localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(NUM_BLOCKS);

    // Control and list state.
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [LINK_W-1:0] head_reg, head_next;
    logic [LINK_W-1:0] fresh_reg, fresh_next;
    logic [LINK_W-1:0] free_cnt_reg, free_cnt_next;
    logic [LINK_W-1:0] used_cnt_reg, used_cnt_next;
    logic [TOTAL_W-1:0] alloc_tot_reg, alloc_tot_next;
    logic [TOTAL_W-1:0] free_tot_reg, free_tot_next;

    // Captured request and result.
    logic             action_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             in_range_reg;
    rsp_t             rsp_reg, rsp_next;

    // Memory ports.
    logic              accept;
    logic [LINK_W-1:0] link_rd_data;
    logic              mark_rd_data;
    logic              link_we;
    logic              mark_we;
    logic [IDX_W-1:0]  mark_wr_addr;
    logic              mark_wr_data;

    assign accept = start && !busy_reg;

    fbpa_store #(
        .DEPTH  (NUM_BLOCKS),
        .IDX_W  (IDX_W),
        .LINK_W (LINK_W)
    ) u_store (
        .clk          (clk),
        .rd_en        (accept),
        .link_rd_addr (head_reg[IDX_W-1:0]),
        .mark_rd_addr (request.block_index[IDX_W-1:0]),
        .link_rd_data (link_rd_data),
        .mark_rd_data (mark_rd_data),
        .link_we      (link_we),
        .link_wr_addr (idx_reg),
        .link_wr_data (head_reg),
        .mark_we      (mark_we),
        .mark_wr_addr (mark_wr_addr),
        .mark_wr_data (mark_wr_data)
    );

    // Execute the captured request with the memory read data.
    always_comb
    begin
        logic empty;
        logic from_fresh;
        logic in_use;

        busy_next      = accept;
        done_next      = busy_reg;
        head_next      = head_reg;
        fresh_next     = fresh_reg;
        free_cnt_next  = free_cnt_reg;
        used_cnt_next  = used_cnt_reg;
        alloc_tot_next = alloc_tot_reg;
        free_tot_next  = free_tot_reg;
        link_we        = 1'b0;
        mark_we        = 1'b0;
        mark_wr_addr   = idx_reg;
        mark_wr_data   = 1'b0;
        rsp_next       = rsp_reg;

        empty      = (head_reg == NULL_LINK);
        from_fresh = (head_reg == fresh_reg);
        // A block at or above the high-water mark was never handed out, so it is free.
        in_use     = (LINK_W'(idx_reg) < fresh_reg) && mark_rd_data;

        if (busy_reg)
        begin
            rsp_next.granted_index = '0;
            rsp_next.status        = ST_OK;
            if (action_reg == ACT_ALLOC)
            begin
                if (empty)
                begin
                    rsp_next.status = ST_EMPTY;
                end
                else
                begin
                    rsp_next.granted_index = INDEX_W'(head_reg);
                    // A never-used head links to the next block in index order.
                    if (from_fresh)
                    begin
                        head_next  = head_reg + 1'b1;
                        fresh_next = fresh_reg + 1'b1;
                    end
                    else
                    begin
                        head_next = link_rd_data;
                    end
                    mark_we        = 1'b1;
                    mark_wr_addr   = head_reg[IDX_W-1:0];
                    mark_wr_data   = 1'b1;
                    free_cnt_next  = free_cnt_reg - 1'b1;
                    used_cnt_next  = used_cnt_reg + 1'b1;
                    alloc_tot_next = alloc_tot_reg + 1'b1;
                end
            end
            else
            begin
                priority if (!in_range_reg)
                begin
                    rsp_next.status = ST_INVALID;
                end
                else if (!in_use)
                begin
                    rsp_next.status = ST_DOUBLE;
                end
                else
                begin
                    // Push the block on the head of the list.
                    link_we       = 1'b1;
                    mark_we       = 1'b1;
                    mark_wr_data  = 1'b0;
                    head_next     = LINK_W'(idx_reg);
                    free_cnt_next = free_cnt_reg + 1'b1;
                    used_cnt_next = used_cnt_reg - 1'b1;
                    free_tot_next = free_tot_reg + 1'b1;
                end
            end
            rsp_next.free_blocks = COUNT_W'(free_cnt_next);
            rsp_next.used_blocks = COUNT_W'(used_cnt_next);
            rsp_next.alloc_total = alloc_tot_next;
            rsp_next.free_total  = free_tot_next;
        end
    end

    // Control state and counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            done_reg      <= 1'b0;
            head_reg      <= '0;
            fresh_reg     <= '0;
            free_cnt_reg  <= NULL_LINK;
            used_cnt_reg  <= '0;
            alloc_tot_reg <= '0;
            free_tot_reg  <= '0;
        end
        else
        begin
            busy_reg      <= busy_next;
            done_reg      <= done_next;
            head_reg      <= head_next;
            fresh_reg     <= fresh_next;
            free_cnt_reg  <= free_cnt_next;
            used_cnt_reg  <= used_cnt_next;
            alloc_tot_reg <= alloc_tot_next;
            free_tot_reg  <= free_tot_next;
        end
    end

    // Request capture and result register.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            action_reg   <= request.action;
            idx_reg      <= request.block_index[IDX_W-1:0];
            in_range_reg <= ({1'b0, request.block_index} < (INDEX_W + 1)'(NUM_BLOCKS));
        end
        rsp_reg <= rsp_next;
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = rsp_reg;

endmodule

// ----- tb/tb_fixed_block_pool_allocator.sv -----
// Self-checking testbench for the fixed block pool allocator.
module tb_fixed_block_pool_allocator;

    import fbpa_pkg::*;

    localparam int POOL_SIZE   = 256;
    localparam int ITEM_TARGET = 1050;
    localparam int CALM_TAIL   = 150;
    localparam int STALL_LIMIT = 200;
    localparam int SETTLE_CYC  = 6;

    logic clk;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    req_t request = '0;
    logic busy;
    logic done;
    rsp_t result;

    fixed_block_pool_allocator #(
        .NUM_BLOCKS(POOL_SIZE)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .request(request),
        .busy(busy),
        .done(done),
        .result(result)
    );

    // Shadow copy of the pool: free list links, head, in-use marks and counters.
    logic [COUNT_W-1:0] link_next [0:POOL_SIZE-1];
    logic               block_taken [0:POOL_SIZE-1];
    logic [COUNT_W-1:0] list_top;
    logic [COUNT_W-1:0] n_free;
    logic [COUNT_W-1:0] n_used;
    logic [TOTAL_W-1:0] grant_total;
    logic [TOTAL_W-1:0] release_total;

    rsp_t pending_results [$];
    bit   sender_gaps = 1'b1;
    int   sent_count = 0;
    int   fault_count = 0;
    int   stall_cycles = 0;
    int   status_seen [0:3] = '{0, 0, 0, 0};

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Put the shadow pool into its post-reset state.
    function automatic void clear_pool_shadow();
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            link_next[i]   = COUNT_W'(i + 1);
            block_taken[i] = 1'b0;
        end
        list_top      = '0;
        n_free        = COUNT_W'(POOL_SIZE);
        n_used        = '0;
        grant_total   = '0;
        release_total = '0;
    endfunction

    // Apply one request to the shadow pool and return the result it must produce.
    function automatic rsp_t apply_request(req_t item);
        rsp_t               r;
        logic [COUNT_W-1:0] blk;
        r = '0;
        if (item.action == ACT_ALLOC)
        begin
            if (list_top >= POOL_SIZE)
            begin
                r.status = ST_EMPTY;
            end
            else
            begin
                blk              = list_top;
                r.granted_index  = INDEX_W'(blk);
                list_top         = link_next[blk];
                block_taken[blk] = 1'b1;
                n_used           = n_used + 1'b1;
                n_free           = n_free - 1'b1;
                grant_total      = grant_total + 1'b1;
                r.status         = ST_OK;
            end
        end
        else
        begin
            if (item.block_index >= POOL_SIZE)
            begin
                r.status = ST_INVALID;
            end
            else if (!block_taken[item.block_index])
            begin
                r.status = ST_DOUBLE;
            end
            else
            begin
                blk              = COUNT_W'(item.block_index);
                block_taken[blk] = 1'b0;
                link_next[blk]   = list_top;
                list_top         = blk;
                n_used           = n_used - 1'b1;
                n_free           = n_free + 1'b1;
                release_total    = release_total + 1'b1;
                r.status         = ST_OK;
            end
        end
        r.free_blocks = n_free;
        r.used_blocks = n_used;
        r.alloc_total = grant_total;
        r.free_total  = release_total;
        return r;
    endfunction

    // Find a block currently handed out, starting from a random place; -1 if none.
    function automatic int pick_taken_block();
        int base;
        int idx;
        base = $urandom_range(0, POOL_SIZE - 1);
        for (int k = 0; k < POOL_SIZE; k++)
        begin
            idx = (base + k) % POOL_SIZE;
            if (block_taken[idx])
                return idx;
        end
        return -1;
    endfunction

    // An index that is most likely refused: out of range or possibly not in use.
    function automatic logic [INDEX_W-1:0] stray_index();
        case ($urandom_range(0, 3))
            0: return INDEX_W'($urandom_range(0, 65535));
            1: return INDEX_W'(POOL_SIZE + $urandom_range(0, 3));
            2: return INDEX_W'(65535 - $urandom_range(0, 3));
            default: return INDEX_W'($urandom_range(0, POOL_SIZE - 1));
        endcase
    endfunction

    // Drive one request, wait for the transfer and record its expected result.
    task automatic send_request(input logic act, input logic [INDEX_W-1:0] idx);
        req_t item;
        item.action      = act;
        item.block_index = idx;
        if (sender_gaps && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        start   <= 1'b1;
        request <= item;
        // Busy only changes on a rising edge, so its value at the falling edge
        // decides whether the next rising edge takes the transfer.
        do
            @(negedge clk);
        while (busy);
        pending_results.push_back(apply_request(item));
        status_seen[pending_results[$].status]++;
        sent_count++;
        @(posedge clk);
    endtask

    // Free a block in use, or a stray index if none is in use or by the given percent chance.
    task automatic free_taken_or_stray(input int stray_pct);
        int blk;
        blk = pick_taken_block();
        if (blk < 0 || $urandom_range(0, 99) < stray_pct)
            send_request(ACT_FREE, stray_index());
        else
            send_request(ACT_FREE, INDEX_W'(blk));
    endtask

    // Boundary indices, LIFO reuse, double frees and an ignored index on allocate.
    task automatic test_directed();
        send_request(ACT_FREE, 16'hFFFF);
        send_request(ACT_FREE, INDEX_W'(POOL_SIZE));
        send_request(ACT_FREE, INDEX_W'(POOL_SIZE - 1));
        send_request(ACT_FREE, 16'h0000);
        send_request(ACT_ALLOC, 16'hFFFF);
        send_request(ACT_ALLOC, 16'h5555);
        send_request(ACT_ALLOC, 16'hAAAA);
        send_request(ACT_FREE, 16'd1);
        send_request(ACT_ALLOC, 16'h0000);
        send_request(ACT_FREE, 16'd0);
        send_request(ACT_FREE, 16'd0);
        send_request(ACT_FREE, 16'h8000);
        send_request(ACT_FREE, 16'd2);
        send_request(ACT_FREE, 16'd1);
        send_request(ACT_ALLOC, 16'h0000);
        send_request(ACT_ALLOC, 16'h0000);
        send_request(ACT_FREE, 16'h0100);
        send_request(ACT_FREE, 16'h7FFF);
    endtask

    // Allocation-heavy traffic until the pool has run dry several times over.
    task automatic test_fill_to_empty();
        int empties;
        int steps;
        empties = 0;
        steps   = 0;
        while (empties < 4 && steps < 600)
        begin
            if ($urandom_range(0, 9) != 0)
            begin
                if (list_top >= POOL_SIZE)
                    empties++;
                send_request(ACT_ALLOC, INDEX_W'($urandom_range(0, 65535)));
            end
            else
            begin
                free_taken_or_stray(50);
            end
            steps++;
        end
    endtask

    // Hold the sender off until every outstanding result has come back.
    task automatic test_quiet_drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        send_request(ACT_FREE, 16'hFFFF);
        send_request(ACT_ALLOC, 16'h0000);
    endtask

    // Release-heavy traffic until every block is back in the pool.
    task automatic test_release_all();
        int steps;
        steps = 0;
        while (n_used != 0 && steps < 600)
        begin
            if ($urandom_range(0, 19) == 0)
                send_request(ACT_ALLOC, INDEX_W'($urandom_range(0, 65535)));
            else
                free_taken_or_stray(10);
            steps++;
        end
        repeat (4) send_request(ACT_FREE, stray_index());
    endtask

    // Balanced mix up to the item target; the last stretch runs without gaps.
    task automatic test_random_mix();
        while (sent_count < ITEM_TARGET)
        begin
            if (sent_count >= ITEM_TARGET - CALM_TAIL)
                sender_gaps = 1'b0;
            if ($urandom_range(0, 99) < 55)
                send_request(ACT_ALLOC, INDEX_W'($urandom_range(0, 65535)));
            else
                free_taken_or_stray(15);
        end
    endtask

    // Result checker and stall counter, both sampled at the falling edge.
    always @(negedge clk)
    begin
        rsp_t want;
        if ((start && !busy) || done)
            stall_cycles = 0;
        else
            stall_cycles = stall_cycles + 1;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                fault_count++;
                if (fault_count <= 10)
                    $display("Unexpected result with no request outstanding: status=%0d",
                             result.status);
            end
            else
            begin
                want = pending_results.pop_front();
                if (result.status !== want.status
                    || result.granted_index !== want.granted_index
                    || result.free_blocks !== want.free_blocks
                    || result.used_blocks !== want.used_blocks
                    || result.alloc_total !== want.alloc_total
                    || result.free_total !== want.free_total)
                begin
                    fault_count++;
                    if (fault_count <= 10)
                    begin
                        $display("Mismatch: expected status=%0d index=%0d free=%0d used=%0d",
                                 want.status, want.granted_index, want.free_blocks,
                                 want.used_blocks);
                        $display("          expected allocs=%0d frees=%0d",
                                 want.alloc_total, want.free_total);
                        $display("          got      status=%0d index=%0d free=%0d used=%0d",
                                 result.status, result.granted_index, result.free_blocks,
                                 result.used_blocks);
                        $display("          got      allocs=%0d frees=%0d",
                                 result.alloc_total, result.free_total);
                    end
                end
            end
        end
    end

    // Watchdog: ends the run when no transfer has happened for too long.
    initial
    begin
        while (stall_cycles < STALL_LIMIT)
            @(negedge clk);
        $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    // Test sequence.
    initial
    begin
        clear_pool_shadow();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_fill_to_empty();
        test_quiet_drain();
        test_release_all();
        test_random_mix();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
        $display("Ran %0d requests: %0d successes, %0d pool empty, %0d invalid, %0d double free.",
                 sent_count, status_seen[ST_OK], status_seen[ST_EMPTY],
                 status_seen[ST_INVALID], status_seen[ST_DOUBLE]);
        $display("Totals at end: %0d blocks handed out, %0d returned; %0d faults.",
                 grant_total, release_total, fault_count);
        if (fault_count == 0 && pending_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/fbpa_pkg.sv
hw/rtl/fbpa_store.sv
hw/rtl/fixed_block_pool_allocator.sv
tb/tb_fixed_block_pool_allocator.sv
